// ===== design/tdr_pkg.sv =====
// ---------------------------------------------------------------------------
// tdr_pkg : shared types and constants of the TFTP data receiver
// Defines the item kinds, result actions, protocol constants and the result
// beat layout.
// ---------------------------------------------------------------------------
package tdr_pkg;

  typedef enum logic [1:0] {
    KIND_START  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_BYTE   = 2'd2,
    KIND_TICK   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ACT_WRITE = 3'd0,
    ACT_REPLY = 3'd1,
    ACT_ABORT = 3'd2,
    ACT_NAK   = 3'd3,
    ACT_FAIL  = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    CFG_ASCII_MODE   = 2'd0,
    CFG_SEGMENT_SIZE = 2'd1,
    CFG_TIMEOUT_BASE = 2'd2
  } cfg_idx_t;

  localparam logic [15:0] OP_DATA       = 16'd3;
  localparam logic [15:0] OP_ERROR      = 16'd5;
  localparam logic [7:0]  CR_BYTE       = 8'd13;
  localparam logic [7:0]  DEFAULT_BASE  = 8'd5;
  localparam logic [15:0] HEADER_BYTES  = 16'd4;
  localparam logic [15:0] RESET_SEGMENT = 16'd512;

  typedef struct packed {
    action_t     action;
    logic [15:0] reply_block;
    logic        reply_initial;
    logic        final_res;
    logic [7:0]  out_byte;
    logic [10:0] wait_ticks;
    logic [31:0] bytes_total;
    logic        last;
  } result_t;

endpackage

// ===== design/tftp_data_receiver.sv =====
// ---------------------------------------------------------------------------
// tftp_data_receiver : receiving side of a TFTP transfer
// Checks packet headers, converts netascii payload, emits byte writes,
// replies, aborts and timeout failures as result beats.
// ---------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------
//  in_     | input     | in_valid/in_stall  | kind, opcode, block_num, length, byte
//  out_    | output    | out_valid/out_stall| action, reply block, flags, byte,
//          |           |                    | wait ticks, byte total, last
//  cfg_    | input     | cfg_we             | cfg_index, cfg_wdata (16 bits)
//
//  One input beat is taken per cycle unless stalled. Its whole effect on the
//  transfer state is computed in the cycle it is accepted, and its result beats,
//  up to two, land in a four-entry result queue that drives the output one beat
//  per cycle unless out_stall is high. A written payload byte that also completes
//  a packet yields two beats; the queue stalls the input while fewer than two
//  free slots remain. Reset (rst_n low, synchronous) empties the queue, returns
//  to idle and restores the register defaults.
// ---------------------------------------------------------------------------
module tftp_data_receiver #(
  parameter int MAX_RETRIES = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  // input beats
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [15:0] in_opcode,
  input  logic [15:0] in_block_num,
  input  logic [15:0] in_packet_length,
  input  logic [7:0]  in_data_byte,
  // result beats
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_action,
  output logic [15:0] out_reply_block,
  output logic        out_reply_initial,
  output logic        out_final_res,
  output logic [7:0]  out_out_byte,
  output logic [10:0] out_wait_ticks,
  output logic [31:0] out_bytes_total,
  output logic        out_last
);
  import tdr_pkg::*;

  localparam int RETRY_W = $clog2(MAX_RETRIES + 1);
  localparam int MULT_W  = 8 + RETRY_W + 1;
  localparam int DEPTH   = 4;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_WAIT    = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  // configuration registers
  logic              ascii_mode_r;
  logic [15:0]       segment_size_r;
  logic [7:0]        timeout_base_r;

  // transfer state
  phase_t            phase_r,          phase_nxt;
  logic [15:0]       expected_block_r, expected_block_nxt;
  logic [RETRY_W-1:0] retry_r,         retry_nxt;
  logic              pending_cr_r,     pending_cr_nxt;
  logic [15:0]       bytes_left_r,     bytes_left_nxt;
  logic              short_r,          short_nxt;
  logic              any_ack_r,        any_ack_nxt;
  logic [31:0]       byte_count_r,     byte_count_nxt;

  // result queue
  result_t           fifo_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r;

  logic              in_fire, out_fire;
  kind_t             kind;
  logic [7:0]        base_eff;
  logic [RETRY_W:0]  retry_p1, retry_p2;
  logic [MULT_W-1:0] prod_now, prod_tick;
  logic [10:0]       wait_now, wait_tick, ack_wait;
  logic [15:0]       resend_blk;
  logic              resend_init;
  logic [16:0]       full_len;
  logic [15:0]       len_left;
  logic              do_write, do_ack;
  logic [7:0]        wr_byte;
  logic [15:0]       left_dec;
  logic [1:0]        n_res;
  result_t           res0, res1, ack_res;

  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;
  assign kind     = kind_t'(in_kind);

  // Hold the input whenever a two-beat item might not fit.
  assign in_stall  = count_r > CNT_W'(DEPTH - 2);
  assign out_valid = count_r != '0;

  // Reply timer: base times (retries + 1), zero base means the default.
  assign base_eff  = (timeout_base_r == 8'd0) ? DEFAULT_BASE : timeout_base_r;
  assign retry_p1  = {1'b0, retry_r} + (RETRY_W + 1)'(1);
  assign retry_p2  = {1'b0, retry_r} + (RETRY_W + 1)'(2);
  assign prod_now  = MULT_W'(base_eff) * MULT_W'(retry_p1);
  assign prod_tick = MULT_W'(base_eff) * MULT_W'(retry_p2);
  assign wait_now  = 11'(prod_now);
  assign wait_tick = 11'(prod_tick);

  // Resend repeats the initial reply until some ACK went out.
  assign resend_blk  = any_ack_r ? (expected_block_r - 16'd1) : 16'd0;
  assign resend_init = !any_ack_r;

  assign full_len = {1'b0, segment_size_r} + {1'b0, HEADER_BYTES};
  assign len_left = (in_packet_length >= HEADER_BYTES) ?
                    (in_packet_length - HEADER_BYTES) : 16'd0;
  assign left_dec = bytes_left_r - 16'd1;

  always_comb begin
    phase_nxt          = phase_r;
    expected_block_nxt = expected_block_r;
    retry_nxt          = retry_r;
    pending_cr_nxt     = pending_cr_r;
    bytes_left_nxt     = bytes_left_r;
    short_nxt          = short_r;
    any_ack_nxt        = any_ack_r;
    byte_count_nxt     = byte_count_r;
    res0               = '0;
    res1               = '0;
    ack_res            = '0;
    n_res              = 2'd0;
    do_write           = 1'b0;
    do_ack             = 1'b0;
    wr_byte            = in_data_byte;
    ack_wait           = wait_now;

    unique case (kind)
      KIND_START: begin
        // Restart from scratch and send the initial reply.
        phase_nxt          = PH_WAIT;
        expected_block_nxt = 16'd1;
        retry_nxt          = '0;
        pending_cr_nxt     = 1'b0;
        bytes_left_nxt     = 16'd0;
        short_nxt          = 1'b0;
        any_ack_nxt        = 1'b0;
        byte_count_nxt     = 32'd0;
        res0.action        = ACT_REPLY;
        res0.reply_initial = 1'b1;
        res0.wait_ticks    = 11'(base_eff);
        n_res              = 2'd1;
      end
      KIND_HEADER: begin
        if (phase_r == PH_WAIT) begin
          retry_nxt = '0;
          priority if (in_opcode == OP_ERROR) begin
            phase_nxt   = PH_IDLE;
            res0.action = ACT_ABORT;
            n_res       = 2'd1;
          end else if (in_opcode != OP_DATA) begin
            phase_nxt   = PH_IDLE;
            res0.action = ACT_NAK;
            n_res       = 2'd1;
          end else if (in_block_num != expected_block_r) begin
            res0.action        = ACT_REPLY;
            res0.reply_block   = resend_blk;
            res0.reply_initial = resend_init;
            res0.wait_ticks    = 11'(base_eff);
            n_res              = 2'd1;
          end else begin
            bytes_left_nxt = len_left;
            short_nxt      = {1'b0, in_packet_length} != full_len;
            ack_wait       = 11'(base_eff);
            if (len_left == 16'd0) begin
              do_ack = 1'b1;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
      end
      KIND_BYTE: begin
        if (phase_r == PH_PAYLOAD) begin
          if (ascii_mode_r) begin
            // CR NUL becomes CR, CR x becomes x; a bare CR waits for its partner.
            if (pending_cr_r) begin
              pending_cr_nxt = 1'b0;
              do_write       = 1'b1;
              wr_byte        = (in_data_byte == 8'd0) ? CR_BYTE : in_data_byte;
            end else if (in_data_byte == CR_BYTE) begin
              pending_cr_nxt = 1'b1;
            end else begin
              do_write = 1'b1;
            end
          end else begin
            do_write = 1'b1;
          end
          bytes_left_nxt = left_dec;
          do_ack         = left_dec == 16'd0;
        end
      end
      KIND_TICK: begin
        if (phase_r == PH_WAIT) begin
          if (retry_r < RETRY_W'(MAX_RETRIES)) begin
            retry_nxt          = retry_r + RETRY_W'(1);
            res0.action        = ACT_REPLY;
            res0.reply_block   = resend_blk;
            res0.reply_initial = resend_init;
            res0.wait_ticks    = wait_tick;
            n_res              = 2'd1;
          end else begin
            phase_nxt   = PH_IDLE;
            res0.action = ACT_FAIL;
            n_res       = 2'd1;
          end
        end
      end
      default: begin
        n_res = 2'd0;
      end
    endcase

    if (do_write && byte_count_r != 32'hFFFF_FFFF) begin
      byte_count_nxt = byte_count_r + 32'd1;
    end

    // The ACK closes the packet; a short packet ends the transfer.
    if (do_ack) begin
      ack_res.action      = ACT_REPLY;
      ack_res.reply_block = expected_block_r;
      ack_res.final_res   = short_nxt;
      ack_res.wait_ticks  = short_nxt ? 11'd0 : ack_wait;
      phase_nxt           = short_nxt ? PH_IDLE : PH_WAIT;
      expected_block_nxt  = expected_block_r + 16'd1;
      any_ack_nxt         = 1'b1;
    end

    if (kind == KIND_BYTE || kind == KIND_HEADER) begin
      if (do_write) begin
        res0.action   = ACT_WRITE;
        res0.out_byte = wr_byte;
        res1          = ack_res;
        n_res         = do_ack ? 2'd2 : 2'd1;
      end else if (do_ack) begin
        res0  = ack_res;
        n_res = 2'd1;
      end
    end

    res0.bytes_total = byte_count_nxt;
    res1.bytes_total = byte_count_nxt;
    res0.last        = n_res == 2'd1;
    res1.last        = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ascii_mode_r     <= 1'b0;
      segment_size_r   <= RESET_SEGMENT;
      timeout_base_r   <= DEFAULT_BASE;
      phase_r          <= PH_IDLE;
      expected_block_r <= 16'd1;
      retry_r          <= '0;
      pending_cr_r     <= 1'b0;
      bytes_left_r     <= 16'd0;
      short_r          <= 1'b0;
      any_ack_r        <= 1'b0;
      byte_count_r     <= 32'd0;
      wr_ptr_r         <= '0;
      rd_ptr_r         <= '0;
      count_r          <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_ASCII_MODE:   ascii_mode_r   <= cfg_wdata[0];
          CFG_SEGMENT_SIZE: segment_size_r <= cfg_wdata;
          CFG_TIMEOUT_BASE: timeout_base_r <= cfg_wdata[7:0];
          default: begin
            // unmapped index: drop the write
          end
        endcase
      end
      if (in_fire) begin
        phase_r          <= phase_nxt;
        expected_block_r <= expected_block_nxt;
        retry_r          <= retry_nxt;
        pending_cr_r     <= pending_cr_nxt;
        bytes_left_r     <= bytes_left_nxt;
        short_r          <= short_nxt;
        any_ack_r        <= any_ack_nxt;
        byte_count_r     <= byte_count_nxt;
        wr_ptr_r         <= wr_ptr_r + PTR_W'(n_res);
      end
      if (out_fire) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      count_r <= count_r + (in_fire ? CNT_W'(n_res) : CNT_W'(0))
                         - (out_fire ? CNT_W'(1) : CNT_W'(0));
    end
  end

  // Result queue storage: no reset needed.
  always_ff @(posedge clk) begin
    if (in_fire && n_res != 2'd0) begin
      fifo_r[wr_ptr_r] <= res0;
    end
    if (in_fire && n_res == 2'd2) begin
      fifo_r[wr_ptr_r + PTR_W'(1)] <= res1;
    end
  end

  assign out_action        = fifo_r[rd_ptr_r].action;
  assign out_reply_block   = fifo_r[rd_ptr_r].reply_block;
  assign out_reply_initial = fifo_r[rd_ptr_r].reply_initial;
  assign out_final_res     = fifo_r[rd_ptr_r].final_res;
  assign out_out_byte      = fifo_r[rd_ptr_r].out_byte;
  assign out_wait_ticks    = fifo_r[rd_ptr_r].wait_ticks;
  assign out_bytes_total   = fifo_r[rd_ptr_r].bytes_total;
  assign out_last          = fifo_r[rd_ptr_r].last;

  // Queue never overfills.
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("result queue over capacity");

  // A start always leaves a reply waiting, with the block counter rewound.
  a_start_reply: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && kind == KIND_START |=> count_r != '0 && expected_block_r == 16'd1)
    else $error("start beat produced no reply");

  // The last payload byte always leaves the payload phase.
  a_payload_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && kind == KIND_BYTE && phase_r == PH_PAYLOAD && bytes_left_r == 16'd1
    |=> phase_r != PH_PAYLOAD)
    else $error("payload phase outlived its byte count");

  // Retries stay within the allowed number.
  a_retry_bound: assert property (@(posedge clk) disable iff (!rst_n)
    retry_r <= RETRY_W'(MAX_RETRIES))
    else $error("retry count beyond limit");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench : self-checking bench for the TFTP data receiver
// Drives start, header, payload and tick beats through the input channel,
// predicts every result beat with a cycle-free transfer model kept in step
// with the register writes, and compares each result beat field by field.
// ---------------------------------------------------------------------------
module testbench;
  import tdr_pkg::*;

  localparam int RETRY_LIMIT   = 5;
  localparam int SETTLE_CYCLES = 8;     // block works in the accept cycle; a few spare
  localparam int HOLD_CYCLES   = 120;   // long receiver hold-off, fills the result queue
  localparam int TARGET_ITEMS  = 450;

  // Transfer phases as the bench tracks them.
  typedef enum logic [1:0] {
    RX_IDLE    = 2'd0,
    RX_WAIT    = 2'd1,
    RX_PAYLOAD = 2'd2
  } rx_phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] opcode;
    logic [15:0] block_num;
    logic [15:0] length;
    logic [7:0]  data;
  } in_beat_t;

  typedef struct {
    in_beat_t beat;
    bit       typed;
    result_t  want;
  } dir_row_t;

  // -------------------------------------------------------------------------
  // Clock, reset and DUT ports. Every input starts at a known value.
  // -------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [15:0] cfg_wdata = 16'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_kind = 2'd0;
  logic [15:0] in_opcode = 16'd0;
  logic [15:0] in_block_num = 16'd0;
  logic [15:0] in_packet_length = 16'd0;
  logic [7:0]  in_data_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_action;
  logic [15:0] out_reply_block;
  logic        out_reply_initial;
  logic        out_final_res;
  logic [7:0]  out_out_byte;
  logic [10:0] out_wait_ticks;
  logic [31:0] out_bytes_total;
  logic        out_last;

  always #5 clk = ~clk;

  tftp_data_receiver #(
    .MAX_RETRIES(RETRY_LIMIT)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_opcode        (in_opcode),
    .in_block_num     (in_block_num),
    .in_packet_length (in_packet_length),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_action       (out_action),
    .out_reply_block  (out_reply_block),
    .out_reply_initial(out_reply_initial),
    .out_final_res    (out_final_res),
    .out_out_byte     (out_out_byte),
    .out_wait_ticks   (out_wait_ticks),
    .out_bytes_total  (out_bytes_total),
    .out_last         (out_last)
  );

  // -------------------------------------------------------------------------
  // Bench copy of the registers and of the transfer state, at reset values.
  // -------------------------------------------------------------------------
  logic        m_ascii = 1'b0;
  logic [15:0] m_seg   = RESET_SEGMENT;
  logic [7:0]  m_base  = DEFAULT_BASE;

  rx_phase_t   st_phase  = RX_IDLE;
  logic [15:0] nxt_block = 16'd1;
  int unsigned retries   = 0;
  logic        cr_held   = 1'b0;
  logic [15:0] remain    = 16'd0;
  logic        short_pkt = 1'b0;
  logic        acked     = 1'b0;
  logic [31:0] total     = 32'd0;

  result_t  item_beats[$];     // beats caused by the item being predicted
  result_t  awaited_beats[$];  // beats predicted but not yet seen on out_
  logic     item_used;         // last item changed state or gave a result
  int       used_items = 0;
  int       mismatches = 0;
  bit       idle_on = 1'b1;    // random gaps on both channels
  bit       hold_req = 1'b0;   // ask the receiver for one long hold-off
  dir_row_t dir_rows[$];

  // -------------------------------------------------------------------------
  // Transfer predictor
  // -------------------------------------------------------------------------
  function automatic logic [10:0] wait_now();
    logic [10:0] base;
    base = (m_base != 8'd0) ? 11'(m_base) : 11'(DEFAULT_BASE);
    return base * 11'(retries + 1);
  endfunction

  function automatic void add_result(action_t act, logic [15:0] blk, logic init,
                                     logic fin, logic [7:0] data, logic [10:0] wt);
    result_t r;
    r.action        = act;
    r.reply_block   = blk;
    r.reply_initial = init;
    r.final_res     = fin;
    r.out_byte      = data;
    r.wait_ticks    = wt;
    r.bytes_total   = total;
    r.last          = 1'b0;
    item_beats.push_back(r);
  endfunction

  // Repeat the initial reply until an ACK went out, else re-ACK the last block.
  function automatic void resend_reply();
    if (acked)
      add_result(ACT_REPLY, nxt_block - 16'd1, 1'b0, 1'b0, 8'd0, wait_now());
    else
      add_result(ACT_REPLY, 16'd0, 1'b1, 1'b0, 8'd0, wait_now());
  endfunction

  function automatic void ack_block();
    if (short_pkt) begin
      add_result(ACT_REPLY, nxt_block, 1'b0, 1'b1, 8'd0, 11'd0);
      st_phase = RX_IDLE;
    end else begin
      add_result(ACT_REPLY, nxt_block, 1'b0, 1'b0, 8'd0, wait_now());
      st_phase = RX_WAIT;
    end
    nxt_block = nxt_block + 16'd1;
    acked = 1'b1;
  endfunction

  function automatic void write_out(logic [7:0] data);
    if (total != 32'hFFFF_FFFF)
      total = total + 32'd1;
    add_result(ACT_WRITE, 16'd0, 1'b0, 1'b0, data, 11'd0);
  endfunction

  function automatic void clear_transfer();
    st_phase  = RX_IDLE;
    nxt_block = 16'd1;
    retries   = 0;
    cr_held   = 1'b0;
    remain    = 16'd0;
    short_pkt = 1'b0;
    acked     = 1'b0;
    total     = 32'd0;
  endfunction

  // Advance the transfer by one accepted beat; fill item_beats with its results.
  function automatic void advance_transfer(in_beat_t b);
    result_t r;
    item_beats.delete();
    item_used = 1'b0;
    case (b.kind)
      KIND_START: begin
        item_used = 1'b1;
        clear_transfer();
        st_phase = RX_WAIT;
        resend_reply();
      end
      KIND_HEADER: begin
        if (st_phase == RX_WAIT) begin
          item_used = 1'b1;
          retries = 0;
          if (b.opcode == OP_ERROR) begin
            st_phase = RX_IDLE;
            add_result(ACT_ABORT, 16'd0, 1'b0, 1'b0, 8'd0, 11'd0);
          end else if (b.opcode != OP_DATA) begin
            st_phase = RX_IDLE;
            add_result(ACT_NAK, 16'd0, 1'b0, 1'b0, 8'd0, 11'd0);
          end else if (b.block_num != nxt_block) begin
            resend_reply();
          end else begin
            // Lengths below the header size count as an empty payload.
            remain = (b.length >= HEADER_BYTES) ? b.length - HEADER_BYTES : 16'd0;
            short_pkt = ({1'b0, b.length} != ({1'b0, m_seg} + {1'b0, HEADER_BYTES}));
            if (remain == 16'd0)
              ack_block();
            else
              st_phase = RX_PAYLOAD;
          end
        end
      end
      KIND_BYTE: begin
        if (st_phase == RX_PAYLOAD) begin
          item_used = 1'b1;
          if (m_ascii) begin
            // Netascii: CR NUL gives CR, CR x gives x; a held CR spans packets.
            if (cr_held) begin
              cr_held = 1'b0;
              write_out((b.data == 8'd0) ? CR_BYTE : b.data);
            end else if (b.data == CR_BYTE) begin
              cr_held = 1'b1;
            end else begin
              write_out(b.data);
            end
          end else begin
            write_out(b.data);
          end
          remain = remain - 16'd1;
          if (remain == 16'd0)
            ack_block();
        end
      end
      default: begin
        if (st_phase == RX_WAIT) begin
          item_used = 1'b1;
          if (retries < RETRY_LIMIT) begin
            retries = retries + 1;
            resend_reply();
          end else begin
            st_phase = RX_IDLE;
            add_result(ACT_FAIL, 16'd0, 1'b0, 1'b0, 8'd0, 11'd0);
          end
        end
      end
    endcase
    if (item_beats.size() != 0) begin
      r = item_beats.pop_back();
      r.last = 1'b1;
      item_beats.push_back(r);
    end
  endfunction

  // -------------------------------------------------------------------------
  // Random helpers
  // -------------------------------------------------------------------------
  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (!idle_on)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 65)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] rand16();
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] rand_len();
    return 16'($urandom_range(0, 65468));
  endfunction

  // Lean on CR and NUL so netascii pairs show up often.
  function automatic logic [7:0] rand_data();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2)
      return CR_BYTE;
    if (r < 4)
      return 8'd0;
    return 8'($urandom);
  endfunction

  function automatic in_beat_t beat_of(kind_t k, logic [15:0] op, logic [15:0] blk,
                                       logic [15:0] len, logic [7:0] data);
    in_beat_t b;
    b.kind      = k;
    b.opcode    = op;
    b.block_num = blk;
    b.length    = len;
    b.data      = data;
    return b;
  endfunction

  function automatic void add_row(in_beat_t b, bit typed = 1'b0, action_t act = ACT_WRITE,
                                  logic [15:0] blk = 16'd0, logic init = 1'b0,
                                  logic fin = 1'b0, logic [10:0] wt = 11'd0,
                                  logic [31:0] tot = 32'd0);
    dir_row_t row;
    row.beat = b;
    row.typed = typed;
    row.want.action        = act;
    row.want.reply_block   = blk;
    row.want.reply_initial = init;
    row.want.final_res     = fin;
    row.want.out_byte      = 8'd0;
    row.want.wait_ticks    = wt;
    row.want.bytes_total   = tot;
    row.want.last          = 1'b1;
    dir_rows.push_back(row);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // -------------------------------------------------------------------------
  // Sender side
  // -------------------------------------------------------------------------
  // Offer one beat, hold it until accepted, then predict its results. Typed
  // rows put their hand-written expectation on the queue instead.
  task automatic send_beat(input in_beat_t b, input bit typed = 1'b0,
                           input result_t want = '0);
    int gap;
    in_valid         <= 1'b1;
    in_kind          <= b.kind;
    in_opcode        <= b.opcode;
    in_block_num     <= b.block_num;
    in_packet_length <= b.length;
    in_data_byte     <= b.data;
    do @(posedge clk); while (in_stall);
    advance_transfer(b);
    if (typed)
      awaited_beats.push_back(want);
    else
      foreach (item_beats[i]) awaited_beats.push_back(item_beats[i]);
    if (item_used)
      used_items++;
    // Drop valid only for a real gap; back-to-back beats keep it high.
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off until every awaited beat has arrived and the block has settled.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (awaited_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input cfg_idx_t idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_ASCII_MODE:   m_ascii = val[0];
      CFG_SEGMENT_SIZE: m_seg   = val;
      default:          m_base  = val[7:0];
    endcase
  endtask

  // One transfer: mostly well-formed packets with random content, mixed with
  // timeouts, stale blocks, peer errors, stray beats and cut-off packets.
  task automatic run_transfer();
    int          pkts;
    int          r;
    int          n;
    int          cap;
    logic [15:0] len;
    logic [15:0] op;
    // Stray beat before the start; ignored unless a transfer is still waiting.
    if ($urandom_range(0, 4) == 0)
      send_beat(beat_of(kind_t'($urandom_range(1, 3)), rand16(), rand16(), rand_len(),
                        rand_data()));
    send_beat(beat_of(KIND_START, rand16(), rand16(), rand_len(), rand_data()));
    pkts = $urandom_range(1, 8);
    repeat (pkts) begin
      if (st_phase == RX_IDLE)
        return;
      r = $urandom_range(0, 99);
      if (r < 8) begin
        // Timeout ticks; enough of them run into the failure.
        n = $urandom_range(1, 7);
        repeat (n) begin
          if (st_phase == RX_WAIT)
            send_beat(beat_of(KIND_TICK, rand16(), rand16(), rand_len(), rand_data()));
        end
      end else if (r < 15) begin
        // Stale or future block: resend of the last reply.
        send_beat(beat_of(KIND_HEADER, OP_DATA, nxt_block + 16'($urandom_range(1, 65535)),
                          rand_len(), rand_data()));
      end else if (r < 19) begin
        // Peer error or unknown opcode ends the transfer.
        op = rand16();
        if ($urandom_range(0, 1) == 0 || op == OP_DATA)
          op = OP_ERROR;
        send_beat(beat_of(KIND_HEADER, op, rand16(), rand_len(), rand_data()));
      end else if (r < 23) begin
        // Payload byte while waiting for a header: ignored.
        send_beat(beat_of(KIND_BYTE, rand16(), rand16(), rand_len(), rand_data()));
      end else if (r < 27) begin
        // Long packet cut off by a restart; at times a stray tick in the payload first.
        send_beat(beat_of(KIND_HEADER, OP_DATA, nxt_block, 16'($urandom_range(1000, 65468)),
                          rand_data()));
        n = $urandom_range(0, 5);
        repeat (n) send_beat(beat_of(KIND_BYTE, rand16(), rand16(), rand_len(), rand_data()));
        if ($urandom_range(0, 1) == 0)
          send_beat(beat_of(KIND_TICK, rand16(), rand16(), rand_len(), rand_data()));
        send_beat(beat_of(KIND_START, rand16(), rand16(), rand_len(), rand_data()));
      end else begin
        // Good packet: a full segment where that stays small, else a short one.
        if (m_seg <= 16'd64 && $urandom_range(0, 2) != 0)
          len = m_seg + HEADER_BYTES;
        else if ($urandom_range(0, 9) == 0)
          len = 16'($urandom_range(0, 4));
        else begin
          cap = (m_seg > 16'd40) ? 40 : int'(m_seg) - 1;
          len = HEADER_BYTES + 16'($urandom_range(1, cap));
        end
        send_beat(beat_of(KIND_HEADER, OP_DATA, nxt_block, len, rand_data()));
        while (st_phase == RX_PAYLOAD)
          send_beat(beat_of(KIND_BYTE, rand16(), rand16(), rand_len(), rand_data()));
      end
    end
  endtask

  // -------------------------------------------------------------------------
  // Receiver side: random stalls, plus one long hold-off on request so the
  // result queue fills and the block stalls its input.
  // -------------------------------------------------------------------------
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_gap();
      end
    end
  end

  // -------------------------------------------------------------------------
  // Result monitor: capture each accepted beat at the edge, compare it at
  // the following falling edge so the sender's prediction for the same edge
  // is already queued.
  // -------------------------------------------------------------------------
  initial begin : monitor
    result_t seen;
    result_t want;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        seen.action        = action_t'(out_action);
        seen.reply_block   = out_reply_block;
        seen.reply_initial = out_reply_initial;
        seen.final_res     = out_final_res;
        seen.out_byte      = out_out_byte;
        seen.wait_ticks    = out_wait_ticks;
        seen.bytes_total   = out_bytes_total;
        seen.last          = out_last;
        @(negedge clk);
        if (awaited_beats.size() == 0) begin
          $error("result beat with nothing awaited: action %0d block %0d",
                 seen.action, seen.reply_block);
          mismatches++;
        end else begin
          want = awaited_beats.pop_front();
          check_field("action", 32'(want.action), 32'(seen.action));
          check_field("reply_block", 32'(want.reply_block), 32'(seen.reply_block));
          check_field("reply_initial", 32'(want.reply_initial), 32'(seen.reply_initial));
          check_field("final_res", 32'(want.final_res), 32'(seen.final_res));
          check_field("out_byte", 32'(want.out_byte), 32'(seen.out_byte));
          check_field("wait_ticks", 32'(want.wait_ticks), 32'(seen.wait_ticks));
          check_field("bytes_total", want.bytes_total, seen.bytes_total);
          check_field("last", 32'(want.last), 32'(seen.last));
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  initial begin : stimulus
    int          phase_no;
    int          nxfers;
    logic        a;
    logic [15:0] s;
    logic [7:0]  t;

    // Directed rows, run at the reset register values (512-byte segments,
    // base wait 5, binary mode). Typed rows carry their expected beat.
    add_row(beat_of(KIND_TICK, 16'hFFFF, 16'hFFFF, 16'hFFBC, 8'hFF));   // idle: ignored
    add_row(beat_of(KIND_BYTE, 16'h0000, 16'h0000, 16'h0000, CR_BYTE));  // idle: ignored
    add_row(beat_of(KIND_START, 16'h0000, 16'h0000, 16'h0000, 8'h00),
            1'b1, ACT_REPLY, 16'd0, 1'b1, 1'b0, 11'd5, 32'd0);
    add_row(beat_of(KIND_BYTE, 16'h0000, 16'h0000, 16'h0000, 8'h41));    // waiting: ignored
    add_row(beat_of(KIND_TICK, 16'h0000, 16'h0000, 16'h0000, 8'h00),
            1'b1, ACT_REPLY, 16'd0, 1'b1, 1'b0, 11'd10, 32'd0);
    // Wrong block: initial reply again, retry count cleared by the header.
    add_row(beat_of(KIND_HEADER, OP_DATA, 16'd2, 16'd6, 8'h00),
            1'b1, ACT_REPLY, 16'd0, 1'b1, 1'b0, 11'd5, 32'd0);
    add_row(beat_of(KIND_HEADER, OP_DATA, 16'd1, 16'd6, 8'h00));         // opens 2 bytes
    add_row(beat_of(KIND_BYTE, 16'h0000, 16'h0000, 16'h0000, 8'h00),
            1'b1, ACT_WRITE, 16'd0, 1'b0, 1'b0, 11'd0, 32'd1);
    add_row(beat_of(KIND_BYTE, 16'h0000, 16'h0000, 16'h0000, 8'hFF));    // write + final ACK
    add_row(beat_of(KIND_HEADER, OP_DATA, 16'd2, 16'd6, 8'h00));         // idle: ignored
    add_row(beat_of(KIND_START, 16'h0000, 16'h0000, 16'h0000, 8'h00),
            1'b1, ACT_REPLY, 16'd0, 1'b1, 1'b0, 11'd5, 32'd0);
    // Header shorter than four bytes: empty payload, final ACK at once.
    add_row(beat_of(KIND_HEADER, OP_DATA, 16'd1, 16'd0, 8'h00),
            1'b1, ACT_REPLY, 16'd1, 1'b0, 1'b1, 11'd0, 32'd0);
    add_row(beat_of(KIND_START, 16'h0000, 16'h0000, 16'h0000, 8'h00),
            1'b1, ACT_REPLY, 16'd0, 1'b1, 1'b0, 11'd5, 32'd0);
    add_row(beat_of(KIND_HEADER, OP_ERROR, 16'd1, 16'd4, 8'h00),
            1'b1, ACT_ABORT, 16'd0, 1'b0, 1'b0, 11'd0, 32'd0);
    add_row(beat_of(KIND_START, 16'h0000, 16'h0000, 16'h0000, 8'h00),
            1'b1, ACT_REPLY, 16'd0, 1'b1, 1'b0, 11'd5, 32'd0);
    add_row(beat_of(KIND_HEADER, 16'hFFFF, 16'hFFFF, 16'hFFBC, 8'hFF),
            1'b1, ACT_NAK, 16'd0, 1'b0, 1'b0, 11'd0, 32'd0);
    add_row(beat_of(KIND_START, 16'h0000, 16'h0000, 16'h0000, 8'h00),
            1'b1, ACT_REPLY, 16'd0, 1'b1, 1'b0, 11'd5, 32'd0);
    // Five resends with a growing wait, then the failure.
    repeat (5) add_row(beat_of(KIND_TICK, 16'h0000, 16'h0000, 16'h0000, 8'h00));
    add_row(beat_of(KIND_TICK, 16'h0000, 16'h0000, 16'h0000, 8'h00),
            1'b1, ACT_FAIL, 16'd0, 1'b0, 1'b0, 11'd0, 32'd0);
    add_row(beat_of(KIND_START, 16'hFFFF, 16'hFFFF, 16'hFFBC, 8'hFF),
            1'b1, ACT_REPLY, 16'd0, 1'b1, 1'b0, 11'd5, 32'd0);
    // Exactly four bytes: empty payload as well.
    add_row(beat_of(KIND_HEADER, OP_DATA, 16'd1, 16'd4, 8'h00),
            1'b1, ACT_REPLY, 16'd1, 1'b0, 1'b1, 11'd0, 32'd0);

    // Hold reset, then release it once.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
    wait_idle();

    // Random phases, each with its own register setting; the first ones hit
    // the extremes. The block is idle at every register write.
    phase_no = 0;
    while (used_items < TARGET_ITEMS) begin
      case (phase_no)
        0: begin a = 1'b0; s = 16'd8;     t = 8'd0;   end
        1: begin a = 1'b1; s = 16'd65464; t = 8'd255; end
        2: begin a = 1'b1; s = 16'd8;     t = 8'd1;   end
        default: begin
          a = 1'($urandom_range(0, 1));
          s = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(8, 65464))
                                          : 16'($urandom_range(8, 48));
          t = 8'($urandom);
        end
      endcase
      write_cfg(CFG_ASCII_MODE, {15'd0, a});
      write_cfg(CFG_SEGMENT_SIZE, s);
      write_cfg(CFG_TIMEOUT_BASE, {8'd0, t});
      cfg_we <= 1'b0;

      // Every fourth phase runs without gaps; phase 2 also gets the long
      // receiver hold-off while beats keep coming.
      idle_on = (phase_no % 4 != 3) && (phase_no != 2);
      if (phase_no == 2)
        hold_req = 1'b1;

      nxfers = $urandom_range(3, 6);
      repeat (nxfers) begin
        if (used_items < TARGET_ITEMS)
          run_transfer();
      end
      wait_idle();
      phase_no++;
    end

    // Everything awaited has arrived; give stray beats a chance to show.
    repeat (SETTLE_CYCLES * 4) @(posedge clk);
    if (awaited_beats.size() != 0) begin
      $error("%0d awaited result beats never arrived", awaited_beats.size());
      mismatches++;
    end
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #(5_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== tftp_data_receiver.f =====
design/tdr_pkg.sv
design/tftp_data_receiver.sv
sim/testbench.sv
